[rtl/core/yuv2nv_pkg.sv]
// ----------------------------------------------------------------------------
// YUYV to NV12 converter package
// Shared widths, defaults, register indexes and helpers for the converter.
// ----------------------------------------------------------------------------
package yuv2nv_pkg;

	// Default geometry limits
	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 4096;

	// Field widths
	localparam int PIX_W      = 8;
	localparam int FW_W       = 12;
	localparam int FH_W       = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 1;

	// Register reset values
	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(384);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// Bits to index n entries, never below one
	function automatic int idx_width(input int n);
		idx_width = (n <= 1) ? 1 : $clog2(n);
	endfunction

endpackage

[rtl/core/yuv2nv_pix_if.sv]
// ----------------------------------------------------------------------------
// YUYV macropixel stream interface
// Valid/ready channel carrying one Y0 U Y1 V macropixel as separate bytes.
// ----------------------------------------------------------------------------
interface yuv2nv_pix_if;

	logic                         valid;
	logic                         ready;
	logic [yuv2nv_pkg::PIX_W-1:0] luma_even;
	logic [yuv2nv_pkg::PIX_W-1:0] chroma_u;
	logic [yuv2nv_pkg::PIX_W-1:0] luma_odd;
	logic [yuv2nv_pkg::PIX_W-1:0] chroma_v;

	modport source (output valid, luma_even, chroma_u, luma_odd, chroma_v, input ready);
	modport sink   (input valid, luma_even, chroma_u, luma_odd, chroma_v, output ready);

endinterface

[rtl/core/yuv2nv_nv12_if.sv]
// ----------------------------------------------------------------------------
// NV12 result stream interface
// Valid/ready channel carrying a luma pair, its position and averaged chroma.
// ----------------------------------------------------------------------------
interface yuv2nv_nv12_if #(
	parameter int COL_W  = yuv2nv_pkg::idx_width(yuv2nv_pkg::MAX_WIDTH_DEF / 2),
	parameter int ROW_W  = yuv2nv_pkg::idx_width(yuv2nv_pkg::MAX_HEIGHT_DEF),
	parameter int CROW_W = (ROW_W > 1) ? ROW_W - 1 : 1
);

	logic                         valid;
	logic                         ready;
	logic [yuv2nv_pkg::PIX_W-1:0] luma_first;
	logic [yuv2nv_pkg::PIX_W-1:0] luma_second;
	logic [ROW_W-1:0]             luma_row;
	logic [COL_W-1:0]             pair_column;
	logic                         chroma_valid;
	logic [yuv2nv_pkg::PIX_W-1:0] chroma_u_avg;
	logic [yuv2nv_pkg::PIX_W-1:0] chroma_v_avg;
	logic [CROW_W-1:0]            chroma_row;
	logic                         frame_end;

	modport source (
		output valid, luma_first, luma_second, luma_row, pair_column, chroma_valid,
		       chroma_u_avg, chroma_v_avg, chroma_row, frame_end,
		input  ready
	);
	modport sink (
		input  valid, luma_first, luma_second, luma_row, pair_column, chroma_valid,
		       chroma_u_avg, chroma_v_avg, chroma_row, frame_end,
		output ready
	);

endinterface

[rtl/core/yuyv_to_nv12_converter_core.sv]
// An accepted input transaction passes through the stage 1 register, then the stage 2 result register on pixel_out.
// Throughput: one macropixel per cycle while pixel_out is ready; the single-port line buffer is
// written on even rows and read on odd rows at the accept edge.
// Reset: counters and pipeline valids clear, frame_width 640, frame_height 384.
// The chroma line buffer is not cleared; entries are written only on even rows.
// ----------------------------------------------------------------------------
// YUYV 4:2:2 to NV12 converter core
// Passes luma through with its position and averages U,V over row pairs
// using a line buffer indexed by macropixel column.
// ----------------------------------------------------------------------------
module yuyv_to_nv12_converter_core #(
	parameter  int MAX_WIDTH  = yuv2nv_pkg::MAX_WIDTH_DEF,
	parameter  int MAX_HEIGHT = yuv2nv_pkg::MAX_HEIGHT_DEF,
	localparam int LINE_DEPTH = MAX_WIDTH / 2,
	localparam int COL_W      = yuv2nv_pkg::idx_width(LINE_DEPTH),
	localparam int ROW_W      = yuv2nv_pkg::idx_width(MAX_HEIGHT),
	localparam int CROW_W     = (ROW_W > 1) ? ROW_W - 1 : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [yuv2nv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [yuv2nv_pkg::CFG_DATA_W-1:0] cfg_data,
	yuv2nv_pix_if.sink                        pixel_in,
	yuv2nv_nv12_if.source                     pixel_out
);

	localparam int PIX_W  = yuv2nv_pkg::PIX_W;
	localparam int FW_W   = yuv2nv_pkg::FW_W;
	localparam int FH_W   = yuv2nv_pkg::FH_W;
	localparam int PCMP_W = ((FW_W - 1 > COL_W) ? FW_W - 1 : COL_W) + 1;
	localparam int RCMP_W = ((FH_W > ROW_W) ? FH_W : ROW_W) + 1;

	// Configuration registers
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;

	// Position counters
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// Stage 1: captured macropixel and line buffer read data
	logic              valid_s1;
	logic [PIX_W-1:0]  y0_s1, y1_s1, u_s1, v_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [COL_W-1:0]  col_s1;
	logic              fend_s1;
	logic [2*PIX_W-1:0] line_rd_s1;

	// Stage 2: result register
	logic              valid_s2;
	logic [PIX_W-1:0]  y0_s2, y1_s2, uavg_s2, vavg_s2;
	logic [ROW_W-1:0]  row_s2;
	logic [COL_W-1:0]  col_s2;
	logic              cvalid_s2;
	logic              fend_s2;

	// Line buffer, U high byte, V low byte
	logic [2*PIX_W-1:0] chroma_line [LINE_DEPTH];

	logic               in_acc;
	logic               adv_s2;
	logic [PCMP_W-1:0]  pairs_raw, pairs, col_inc;
	logic [RCMP_W-1:0]  rows_raw, rows, row_inc;
	logic               last_col, last_row;
	logic [PIX_W:0]     usum, vsum;

	// Handshake: stage 1 moves on when the result register is free or drained
	assign adv_s2         = valid_s1 && (!valid_s2 || pixel_out.ready);
	assign pixel_in.ready = !valid_s1 || adv_s2;
	assign in_acc         = pixel_in.valid && pixel_in.ready;

	// Geometry limits, clamped to at least one and at most the maximum
	always_comb begin
		pairs_raw = PCMP_W'(frame_width_q >> 1);
		if (pairs_raw == '0) begin
			pairs = PCMP_W'(1);
		end else if (pairs_raw > PCMP_W'(LINE_DEPTH)) begin
			pairs = PCMP_W'(LINE_DEPTH);
		end else begin
			pairs = pairs_raw;
		end
		rows_raw = RCMP_W'(frame_height_q);
		if (rows_raw == '0) begin
			rows = RCMP_W'(1);
		end else if (rows_raw > RCMP_W'(MAX_HEIGHT)) begin
			rows = RCMP_W'(MAX_HEIGHT);
		end else begin
			rows = rows_raw;
		end
		col_inc  = PCMP_W'(col_q) + PCMP_W'(1);
		row_inc  = RCMP_W'(row_q) + RCMP_W'(1);
		last_col = (col_inc >= pairs);
		last_row = (row_inc >= rows);
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= yuv2nv_pkg::FRAME_WIDTH_RST;
			frame_height_q <= yuv2nv_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_write_en) begin
			unique case (yuv2nv_pkg::cfg_reg_t'(cfg_index))
				yuv2nv_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				yuv2nv_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	// Column and row counters, wrap at the end of a row and of the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Line buffer: store chroma on even rows, read it back on odd rows
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (!row_q[0]) begin
				chroma_line[col_q] <= {pixel_in.chroma_u, pixel_in.chroma_v};
			end else begin
				line_rd_s1 <= chroma_line[col_q];
			end
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel_in.ready) begin
			valid_s1 <= pixel_in.valid;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			y0_s1   <= pixel_in.luma_even;
			y1_s1   <= pixel_in.luma_odd;
			u_s1    <= pixel_in.chroma_u;
			v_s1    <= pixel_in.chroma_v;
			row_s1  <= row_q;
			col_s1  <= col_q;
			fend_s1 <= last_col && last_row;
		end
	end

	// Rounded averages, half up
	assign usum = {1'b0, line_rd_s1[2*PIX_W-1:PIX_W]} + {1'b0, u_s1} + (PIX_W+1)'(1);
	assign vsum = {1'b0, line_rd_s1[PIX_W-1:0]} + {1'b0, v_s1} + (PIX_W+1)'(1);

	// Stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || pixel_out.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			y0_s2     <= y0_s1;
			y1_s2     <= y1_s1;
			row_s2    <= row_s1;
			col_s2    <= col_s1;
			cvalid_s2 <= row_s1[0];
			uavg_s2   <= row_s1[0] ? usum[PIX_W:1] : '0;
			vavg_s2   <= row_s1[0] ? vsum[PIX_W:1] : '0;
			fend_s2   <= fend_s1;
		end
	end

	// Result port
	assign pixel_out.valid        = valid_s2;
	assign pixel_out.luma_first   = y0_s2;
	assign pixel_out.luma_second  = y1_s2;
	assign pixel_out.luma_row     = row_s2;
	assign pixel_out.pair_column  = col_s2;
	assign pixel_out.chroma_valid = cvalid_s2;
	assign pixel_out.chroma_u_avg = uavg_s2;
	assign pixel_out.chroma_v_avg = vavg_s2;
	assign pixel_out.chroma_row   = CROW_W'(row_s2 >> 1);
	assign pixel_out.frame_end    = fend_s2;

	// Chroma is present exactly on odd rows
	a_chroma_odd_row: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (cvalid_s2 == row_s2[0]))
		else $error("chroma_valid does not follow row parity");

	// Last macropixel of the frame returns both counters to zero
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last_col && last_row) |=> (col_q == '0 && row_q == '0))
		else $error("counters did not wrap at frame end");

	// Column counter stays inside the line buffer
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		PCMP_W'(col_q) < PCMP_W'(LINE_DEPTH))
		else $error("column counter beyond line buffer depth");

	// A held stage 1 item moves into an empty result register
	a_pipe_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !valid_s2) |=> valid_s2)
		else $error("stage 1 item did not advance");

endmodule

[tb/nv12_stream_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NV12 stream checker
// Watches the configuration port and both streams of the YUYV to NV12
// converter, predicts every NV12 result from the accepted macropixels and
// compares it with what the converter delivers, oldest first.
// ----------------------------------------------------------------------------
module nv12_stream_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [yuv2nv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [yuv2nv_pkg::CFG_DATA_W-1:0] cfg_data,
	yuv2nv_pix_if                             pix,
	yuv2nv_nv12_if                            nv,
	output int unsigned                       nv12_owed,
	output int unsigned                       nv12_errors
);

	localparam int PIX_W       = yuv2nv_pkg::PIX_W;
	localparam int FW_W        = yuv2nv_pkg::FW_W;
	localparam int FH_W        = yuv2nv_pkg::FH_W;
	localparam int MAX_HEIGHT  = yuv2nv_pkg::MAX_HEIGHT_DEF;
	localparam int LINE_DEPTH  = yuv2nv_pkg::MAX_WIDTH_DEF / 2;
	localparam int COL_W       = $clog2(LINE_DEPTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT);
	localparam int CROW_W      = ROW_W - 1;

	typedef struct packed {
		logic [PIX_W-1:0]  luma_first;
		logic [PIX_W-1:0]  luma_second;
		logic [ROW_W-1:0]  luma_row;
		logic [COL_W-1:0]  pair_column;
		logic              chroma_valid;
		logic [PIX_W-1:0]  chroma_u_avg;
		logic [PIX_W-1:0]  chroma_v_avg;
		logic [CROW_W-1:0] chroma_row;
		logic              frame_end;
	} nv12_pair_t;

	// Shadow geometry and position
	logic [FW_W-1:0]   width_reg;
	logic [FH_W-1:0]   height_reg;
	int unsigned       col_pos;
	int unsigned       row_pos;
	logic [15:0]       chroma_store [LINE_DEPTH];
	nv12_pair_t        expected_nv12 [$];

	function automatic string describe(input nv12_pair_t r);
		return $sformatf("y=%02h/%02h row=%0d col=%0d cv=%0b u=%02h v=%02h crow=%0d end=%0b",
			r.luma_first, r.luma_second, r.luma_row, r.pair_column, r.chroma_valid,
			r.chroma_u_avg, r.chroma_v_avg, r.chroma_row, r.frame_end);
	endfunction

	// One macropixel through the converter: store or average chroma, advance position
	task automatic convert_macropixel(input logic [PIX_W-1:0] y0, u, y1, v,
			output nv12_pair_t res);
		int unsigned pairs;
		int unsigned rows;
		int unsigned slot;
		logic [15:0] held;
		logic        last_col;
		logic        last_row;
		pairs = int'(width_reg) >> 1;
		if (pairs < 1) pairs = 1;
		if (pairs > LINE_DEPTH) pairs = LINE_DEPTH;
		rows = int'(height_reg);
		if (rows < 1) rows = 1;
		if (rows > MAX_HEIGHT) rows = MAX_HEIGHT;
		slot     = col_pos % LINE_DEPTH;
		last_col = (col_pos + 1 >= pairs);
		last_row = (row_pos + 1 >= rows);

		res             = '0;
		res.luma_first  = y0;
		res.luma_second = y1;
		res.luma_row    = ROW_W'(row_pos);
		res.pair_column = COL_W'(col_pos);
		res.chroma_row  = CROW_W'(row_pos >> 1);
		res.frame_end   = last_col && last_row;

		// even rows fill the line, odd rows average against it
		if (!row_pos[0]) begin
			chroma_store[slot] = {u, v};
		end else begin
			held             = chroma_store[slot];
			res.chroma_valid = 1'b1;
			res.chroma_u_avg = PIX_W'((int'(held[15:8]) + int'(u) + 1) >> 1);
			res.chroma_v_avg = PIX_W'((int'(held[7:0]) + int'(v) + 1) >> 1);
		end

		if (last_col) begin
			col_pos = 0;
			row_pos = last_row ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
	endtask

	// Config, prediction on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		nv12_pair_t want;
		nv12_pair_t got;
		if (!arst_n) begin
			width_reg  = yuv2nv_pkg::FRAME_WIDTH_RST;
			height_reg = yuv2nv_pkg::FRAME_HEIGHT_RST;
			col_pos    = 0;
			row_pos    = 0;
			expected_nv12.delete();
			nv12_errors = 0;
		end else begin
			if (cfg_write_en) begin
				if (cfg_index == yuv2nv_pkg::REG_FRAME_WIDTH)
					width_reg = cfg_data[FW_W-1:0];
				else
					height_reg = cfg_data[FH_W-1:0];
			end

			if (pix.valid === 1'b1 && pix.ready === 1'b1) begin
				convert_macropixel(pix.luma_even, pix.chroma_u, pix.luma_odd, pix.chroma_v,
					want);
				expected_nv12.push_back(want);
			end

			if (nv.valid === 1'b1 && nv.ready === 1'b1) begin
				got = '{nv.luma_first, nv.luma_second, nv.luma_row, nv.pair_column,
					nv.chroma_valid, nv.chroma_u_avg, nv.chroma_v_avg, nv.chroma_row,
					nv.frame_end};
				if (expected_nv12.size() == 0) begin
					nv12_errors++;
					$display("%0t: unexpected nv12 result, expected none, actual %s",
						$time, describe(got));
				end else begin
					want = expected_nv12.pop_front();
					if (got !== want) begin
						nv12_errors++;
						$display("%0t: nv12 result mismatch, expected %s, actual %s",
							$time, describe(want), describe(got));
					end
				end
			end
		end
		nv12_owed = expected_nv12.size();
	end

endmodule

[tb/yuyv_to_nv12_converter_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// YUYV to NV12 converter core testbench
// Drives macropixel streams over a range of frame geometries, with random
// idling on both streams, a long output stall and drain pauses; the checker
// beside the core predicts and compares every NV12 result.
// ----------------------------------------------------------------------------
module yuyv_to_nv12_converter_core_test;

	localparam int CFG_DATA_W     = yuv2nv_pkg::CFG_DATA_W;
	localparam int HOLD_CYCLES    = 250;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_ITEMS   = 800;
	// macropixels left in the first row after the five at default width
	localparam int LINE_FILL      = yuv2nv_pkg::MAX_WIDTH_DEF / 2 - 5;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_write_en;
	yuv2nv_pkg::cfg_reg_t  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int unsigned           nv12_owed;
	int unsigned           nv12_errors;
	int unsigned           quiet_cycles = 0;
	bit                    steady = 1'b0;
	bit                    hold_req = 1'b0;

	yuv2nv_pix_if  pix_if ();
	yuv2nv_nv12_if nv12_if ();

	yuyv_to_nv12_converter_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_in     (pix_if),
		.pixel_out    (nv12_if)
	);

	nv12_stream_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pix          (pix_if),
		.nv           (nv12_if),
		.nv12_owed    (nv12_owed),
		.nv12_errors  (nv12_errors)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Mostly zero, sometimes a short gap, rarely a long gap
	function automatic int unsigned idle_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 65) return 0;
		if (roll < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one macropixel and wait for its transaction
	task automatic send_pixel(input logic [7:0] y0, u, y1, v);
		int unsigned gap;
		gap = steady ? 0 : idle_len();
		if (gap != 0) begin
			pix_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_if.valid     <= 1'b1;
		pix_if.luma_even <= y0;
		pix_if.chroma_u  <= u;
		pix_if.luma_odd  <= y1;
		pix_if.chroma_v  <= v;
		do @(posedge clk); while (pix_if.ready !== 1'b1);
	endtask

	task automatic send_random();
		logic [31:0] word;
		word = $urandom;
		send_pixel(word[7:0], word[15:8], word[23:16], word[31:24]);
	endtask

	// Stop offering and wait until every predicted result has arrived
	task automatic drain();
		pix_if.valid <= 1'b0;
		@(negedge clk);
		while (nv12_owed != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic set_geometry(input logic [CFG_DATA_W-1:0] width, height);
		cfg_write_en <= 1'b1;
		cfg_index    <= yuv2nv_pkg::REG_FRAME_WIDTH;
		cfg_data     <= width;
		@(posedge clk);
		cfg_index    <= yuv2nv_pkg::REG_FRAME_HEIGHT;
		cfg_data     <= height;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// Output side: random backpressure, one long hold-off on request
	initial begin
		int unsigned stall;
		nv12_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				nv12_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				stall = steady ? 0 : idle_len();
				if (stall == 0) begin
					nv12_if.ready <= 1'b1;
					@(posedge clk);
				end else begin
					nv12_if.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	// Watchdog on cycles with no transaction on either stream
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (pix_if.valid && pix_if.ready) ||
				(nv12_if.valid && nv12_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus
	initial begin
		int unsigned random_sent;
		int unsigned burst;
		logic [CFG_DATA_W-1:0] width;
		logic [CFG_DATA_W-1:0] height;
		arst_n           <= 1'b0;
		cfg_write_en     <= 1'b0;
		cfg_index        <= yuv2nv_pkg::REG_FRAME_WIDTH;
		cfg_data         <= '0;
		pix_if.valid     <= 1'b0;
		pix_if.luma_even <= '0;
		pix_if.chroma_u  <= '0;
		pix_if.luma_odd  <= '0;
		pix_if.chroma_v  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default geometry, then widen mid-row to a saturated width and a
		// single row so every line entry gets written
		repeat (5) send_random();
		drain();
		set_geometry(13'h0FFF, 13'd1);
		repeat (LINE_FILL) send_random();

		// 2 pairs x 3 rows: byte extremes, rounding, odd height ends on luma only
		drain();
		set_geometry(13'd4, 13'd3);
		send_pixel(8'h00, 8'hFF, 8'hFF, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'h00, 8'h01);
		send_pixel(8'h80, 8'h00, 8'h7F, 8'hFF);
		send_pixel(8'h01, 8'hFF, 8'hFE, 8'h00);
		send_pixel(8'hFF, 8'h00, 8'h00, 8'hFF);
		send_pixel(8'h55, 8'hAA, 8'hAA, 8'h55);

		// width below two and zero height collapse to one macropixel frames
		drain();
		set_geometry(13'd1, 13'd0);
		repeat (2) send_random();
		drain();
		set_geometry(13'd0, 13'd1);
		send_random();

		// odd width drops the spare pixel
		drain();
		set_geometry(13'd7, 13'd2);
		repeat (6) send_random();

		// narrowing mid-row and shortening mid-frame wrap the counters
		drain();
		set_geometry(13'd8, 13'd4);
		repeat (3) send_random();
		drain();
		set_geometry(13'd4, 13'd4);
		repeat (2) send_random();
		drain();
		set_geometry(13'd4, 13'd2);
		repeat (2) send_random();

		// long output hold-off while the input keeps offering
		drain();
		steady   = 1'b1;
		hold_req = 1'b1;
		repeat (60) send_random();
		steady   = 1'b0;

		// random geometry phases, frames cut at arbitrary points
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					7, 8:    width = 13'($urandom_range(0, 300));
					9:       width = 13'($urandom_range(0, 4095));
					default: width = 13'($urandom_range(0, 40));
				endcase
				if ($urandom_range(0, 15) == 0) width[12] = 1'b1;
				case ($urandom_range(0, 9))
					7, 8:    height = 13'($urandom_range(0, 80));
					9:       height = 13'($urandom_range(0, 8191));
					default: height = 13'($urandom_range(0, 9));
				endcase
				drain();
				set_geometry(width, height);
			end
			steady = ($urandom_range(0, 4) == 0);
			burst  = $urandom_range(10, 150);
			repeat (burst) send_random();
			random_sent += burst;
		end

		// one pair per row with saturated height keeps the rows counting
		drain();
		steady = 1'b0;
		set_geometry(13'd2, 13'h1FFF);
		repeat (24) send_random();

		drain();
		repeat (8) @(posedge clk);
		if (nv12_errors == 0 && nv12_owed == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
